/* sv/qrr_pkg.sv */
// Shared types and constants for the quadratic real-root block.
package qrr_pkg;

  // Width of each root result port
  localparam int ROOT_WIDTH = 26;

  // Root classification codes
  typedef enum logic [1:0] {
    KIND_TWO    = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_NONE   = 2'd2,
    KIND_AZERO  = 2'd3
  } root_kind_t;

endpackage

/* sv/quadratic_real_roots.sv */
// Top level: real roots of a*x^2 + b*x + c in signed fixed point.
//
// Fully pipelined: a new coefficient set may be started every clock cycle and
// busy stays low. Each item gives one result, shown for one cycle with
// out_valid high, after passing the product and discriminant registers, the
// two cell chains and the numerator and output registers. The square root
// takes one root bit per cell (COEF_WIDTH+FRAC_BITS+1 cells) and the
// divider one quotient bit per cell (COEF_WIDTH+FRAC_BITS+2 cells).
// Results cannot be held off, so the receiver must take every strobe.
module quadratic_real_roots
  import qrr_pkg::*;
#(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COEF_WIDTH-1:0] in_coef_a,
  input  logic signed [COEF_WIDTH-1:0] in_coef_b,
  input  logic signed [COEF_WIDTH-1:0] in_coef_c,
  output logic                         out_valid,
  output logic [1:0]                   out_root_kind,
  output logic signed [ROOT_WIDTH-1:0] out_root_plus,
  output logic signed [ROOT_WIDTH-1:0] out_root_minus
);

  localparam int CW  = COEF_WIDTH;
  localparam int DW  = 2*CW + 2;           // discriminant
  localparam int NS  = CW + 1 + FRAC_BITS; // root bits / sqrt cells
  localparam int XW  = 2*NS;               // scaled radicand
  localparam int QW  = CW + 2 + FRAC_BITS; // quotient bits / div cells
  localparam int DVW = CW + 1;             // |2a|
  localparam int BW  = CW + FRAC_BITS + 1; // -b scaled
  localparam int SW  = (QW + 1 > ROOT_WIDTH) ? QW + 1 : ROOT_WIDTH;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'd1 << (ROOT_WIDTH-1)) - 64'd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  // Never stalls
  assign busy = 1'b0;

  // Stage 1: capture and multiply
  logic                   v1_r;
  logic signed [CW-1:0]   a1_r, b1_r;
  logic signed [2*CW-1:0] bb1_r, ac1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
  end

  always_ff @(posedge clk) begin
    a1_r  <= in_coef_a;
    b1_r  <= in_coef_b;
    bb1_r <= in_coef_b * in_coef_b;
    ac1_r <= in_coef_a * in_coef_c;
  end

  // Stage 2: discriminant, classification and divider operands
  logic signed [DW-1:0] disc;
  logic signed [CW:0]   a_ext, a_abs;
  logic signed [BW-1:0] b_sc;
  root_kind_t           kind_nxt;
  logic [XW-1:0]        x_nxt;

  logic                 v2_r;
  root_kind_t           kind2_r;
  logic [XW-1:0]        x2_r;
  logic signed [BW-1:0] base2_r;
  logic                 aneg2_r;
  logic [DVW-1:0]       dmag2_r;

  always_comb begin
    disc  = DW'(bb1_r) - (DW'(ac1_r) <<< 2);
    a_ext = (CW+1)'(a1_r);
    a_abs = a_ext[CW] ? -a_ext : a_ext;
    b_sc  = BW'(b1_r) <<< FRAC_BITS;
    if (a1_r == '0)          kind_nxt = KIND_AZERO;
    else if (disc[DW-1])     kind_nxt = KIND_NONE;
    else if (disc == '0)     kind_nxt = KIND_DOUBLE;
    else                     kind_nxt = KIND_TWO;
    x_nxt = (kind_nxt == KIND_TWO) ? (XW'(unsigned'(disc)) << (2*FRAC_BITS)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    kind2_r <= kind_nxt;
    x2_r    <= x_nxt;
    base2_r <= -b_sc;
    aneg2_r <= a1_r[CW-1];
    dmag2_r <= {a_abs[CW-1:0], 1'b0};
  end

  // Square root chain
  logic [XW-1:0]   sx   [0:NS];
  logic [NS+1:0]   srem [0:NS];
  logic [NS-1:0]   sroot[0:NS];

  assign sx[0]    = x2_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    qrr_sqrt_cell #(.NS(NS)) u_cell (
      .clk     (clk),
      .x_in    (sx[i]),
      .rem_in  (srem[i]),
      .root_in (sroot[i]),
      .x_r     (sx[i+1]),
      .rem_r   (srem[i+1]),
      .root_r  (sroot[i+1])
    );
  end

  // Sideband alongside the square root
  localparam int SB1 = 1 + 2 + BW + 1 + DVW;
  logic [SB1-1:0] sb1_in, sb1_out;
  logic                 v3;
  logic [1:0]           kind3;
  logic signed [BW-1:0] base3;
  logic                 aneg3;
  logic [DVW-1:0]       dmag3;

  assign sb1_in = {v2_r, kind2_r, base2_r, aneg2_r, dmag2_r};
  assign {v3, kind3, base3, aneg3, dmag3} = sb1_out;

  qrr_delay #(.W(SB1), .N(NS)) u_sb1 (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (sb1_in),
    .d_out (sb1_out)
  );

  // Stage 3: both numerators, split into sign and magnitude
  logic signed [QW:0] np, nm, np_abs, nm_abs;
  logic               v4_r;
  logic [1:0]         kind4_r;
  logic               negp4_r, negm4_r;
  logic [QW-1:0]      magp4_r, magm4_r;
  logic [DVW-1:0]     dmag4_r;

  always_comb begin
    np     = (QW+1)'(base3) + signed'((QW+1)'(sroot[NS]));
    nm     = (QW+1)'(base3) - signed'((QW+1)'(sroot[NS]));
    np_abs = np[QW] ? -np : np;
    nm_abs = nm[QW] ? -nm : nm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3;
  end

  always_ff @(posedge clk) begin
    kind4_r <= kind3;
    negp4_r <= np[QW] ^ aneg3;
    negm4_r <= nm[QW] ^ aneg3;
    magp4_r <= np_abs[QW-1:0];
    magm4_r <= nm_abs[QW-1:0];
    dmag4_r <= dmag3;
  end

  // Divider chains, one lane per root
  logic [QW-1:0]  pn  [0:QW];
  logic [DVW-1:0] prem[0:QW];
  logic [DVW-1:0] pden[0:QW];
  logic [QW-1:0]  mn  [0:QW];
  logic [DVW-1:0] mrem[0:QW];
  logic [DVW-1:0] mden[0:QW];

  assign pn[0]   = magp4_r;
  assign prem[0] = '0;
  assign pden[0] = dmag4_r;
  assign mn[0]   = magm4_r;
  assign mrem[0] = '0;
  assign mden[0] = dmag4_r;

  for (genvar i = 0; i < QW; i++) begin : g_div
    qrr_div_cell #(.QW(QW), .DVW(DVW)) u_plus (
      .clk    (clk),
      .num_in (pn[i]),
      .rem_in (prem[i]),
      .den_in (pden[i]),
      .num_r  (pn[i+1]),
      .rem_r  (prem[i+1]),
      .den_r  (pden[i+1])
    );
    qrr_div_cell #(.QW(QW), .DVW(DVW)) u_minus (
      .clk    (clk),
      .num_in (mn[i]),
      .rem_in (mrem[i]),
      .den_in (mden[i]),
      .num_r  (mn[i+1]),
      .rem_r  (mrem[i+1]),
      .den_r  (mden[i+1])
    );
  end

  // Sideband alongside the divider
  logic [3:0] sb2_in, sb2_out;
  logic       v5, negp5, negm5;
  logic [1:0] kind5;

  assign sb2_in = {v4_r, kind4_r, negp4_r};
  assign {v5, kind5, negp5} = sb2_out;

  qrr_delay #(.W(4), .N(QW)) u_sb2 (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (sb2_in),
    .d_out (sb2_out)
  );

  logic [0:0] sb3_out;
  qrr_delay #(.W(1), .N(QW)) u_sb3 (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (negm4_r),
    .d_out (sb3_out)
  );
  assign negm5 = sb3_out[0];

  // Output stage: apply sign, saturate, zero when there is no root
  logic signed [SW-1:0] qp, qm, sp, sm;
  logic                 has_root;

  always_comb begin
    qp = SW'(pn[QW]);
    qm = SW'(mn[QW]);
    if (negp5) qp = -qp;
    if (negm5) qm = -qm;
    sp = (qp > SAT_HI) ? SAT_HI : ((qp < SAT_LO) ? SAT_LO : qp);
    sm = (qm > SAT_HI) ? SAT_HI : ((qm < SAT_LO) ? SAT_LO : qm);
    has_root = (kind5 == KIND_TWO) || (kind5 == KIND_DOUBLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= v5;
  end

  always_ff @(posedge clk) begin
    out_root_kind  <= kind5;
    out_root_plus  <= has_root ? ROOT_WIDTH'(sp) : '0;
    out_root_minus <= has_root ? ROOT_WIDTH'(sm) : '0;
  end

  // Checks
  a_noroot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_root_kind == KIND_NONE || out_root_kind == KIND_AZERO)
      |-> out_root_plus == '0 && out_root_minus == '0)
    else $error("roots not zero without a real root");

  a_double_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_kind == KIND_DOUBLE |-> out_root_plus == out_root_minus)
    else $error("double root lanes differ");

  a_sqrt_feed: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && a1_r == '0 |=> x2_r == '0 && kind2_r == KIND_AZERO)
    else $error("zero a item fed a nonzero radicand");

endmodule

/* sv/qrr_sqrt_cell.sv */
// One digit step of the pipelined square root: two radicand bits in, one root bit out.
module qrr_sqrt_cell #(
  parameter int NS = 25
) (
  input  logic            clk,
  input  logic [2*NS-1:0] x_in,
  input  logic [NS+1:0]   rem_in,
  input  logic [NS-1:0]   root_in,
  output logic [2*NS-1:0] x_r,
  output logic [NS+1:0]   rem_r,
  output logic [NS-1:0]   root_r
);

  logic [NS+1:0] rem_sh;
  logic [NS+1:0] trial;
  logic          fits;
  logic [2*NS-1:0] x_nxt;
  logic [NS+1:0]   rem_nxt;
  logic [NS-1:0]   root_nxt;

  // Bring down the next bit pair and try root*4+1
  always_comb begin
    rem_sh   = {rem_in[NS-1:0], x_in[2*NS-1 -: 2]};
    trial    = {root_in, 2'b01};
    fits     = (rem_sh >= trial);
    rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_in[NS-2:0], fits};
    x_nxt    = {x_in[2*NS-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

endmodule

/* sv/qrr_div_cell.sv */
// One restoring division step: one quotient bit per cell, divisor passed along.
module qrr_div_cell #(
  parameter int QW  = 26,
  parameter int DVW = 17
) (
  input  logic           clk,
  input  logic [QW-1:0]  num_in,
  input  logic [DVW-1:0] rem_in,
  input  logic [DVW-1:0] den_in,
  output logic [QW-1:0]  num_r,
  output logic [DVW-1:0] rem_r,
  output logic [DVW-1:0] den_r
);

  logic [DVW:0]   part;
  logic           fits;
  logic [QW-1:0]  num_nxt;
  logic [DVW-1:0] rem_nxt;

  // Shift in the next numerator bit, subtract the divisor if it fits
  always_comb begin
    part    = {rem_in, num_in[QW-1]};
    fits    = (part >= {1'b0, den_in});
    rem_nxt = fits ? DVW'(part - {1'b0, den_in}) : part[DVW-1:0];
    num_nxt = {num_in[QW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_in;
  end

endmodule

/* sv/qrr_delay.sv */
// Fixed-length delay line that carries item sideband next to the cell chains.
module qrr_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [W-1:0] d_in,
  output logic [W-1:0] d_out
);

  logic [W-1:0] tap_r [0:N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) tap_r[i] <= '0;
    end else begin
      tap_r[0] <= d_in;
      for (int i = 1; i < N; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign d_out = tap_r[N-1];

endmodule

/* tb/sv/qrr_checker.sv */
// Checker for the quadratic real-root block: watches items and results, predicts, compares.
`timescale 1ns / 100ps
module qrr_checker
  import qrr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [15:0]           in_coef_a,
  input  logic signed [15:0]           in_coef_b,
  input  logic signed [15:0]           in_coef_c,
  input  logic                         out_valid,
  input  logic [1:0]                   out_root_kind,
  input  logic signed [ROOT_WIDTH-1:0] out_root_plus,
  input  logic signed [ROOT_WIDTH-1:0] out_root_minus,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [ROOT_WIDTH-1:0] rplus;
    logic signed [ROOT_WIDTH-1:0] rminus;
  } roots_t;

  roots_t root_q[$];

  // floor(sqrt(d * 2^16)), restoring digit-by-digit
  function automatic longint unsigned scaled_sqrt(longint unsigned d);
    longint unsigned rem, root, trial, pair;
    int i;
    rem = 0;
    root = 0;
    for (i = 39; i >= 0; i--) begin
      pair = (i >= 8) ? ((d >> (2 * (i - 8))) & 3) : 0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // saturate to the root port range
  function automatic logic signed [ROOT_WIDTH-1:0] clamp_root(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (ROOT_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[ROOT_WIDTH-1:0];
  endfunction

  function automatic roots_t solve_quadratic(logic signed [15:0] ca, logic signed [15:0] cb,
                                             logic signed [15:0] cc);
    roots_t r;
    longint a, b, c, disc, base, den, s;
    a = ca;
    b = cb;
    c = cc;
    r = '0;
    if (a == 0) begin
      r.kind = KIND_AZERO;
      return r;
    end
    disc = b * b - 4 * a * c;
    base = -b * 256;
    den = 2 * a;
    if (disc > 0) begin
      s = longint'(scaled_sqrt(disc));
      r.kind = KIND_TWO;
      r.rplus = clamp_root((base + s) / den);
      r.rminus = clamp_root((base - s) / den);
    end else if (disc == 0) begin
      r.kind = KIND_DOUBLE;
      r.rplus = clamp_root(base / den);
      r.rminus = r.rplus;
    end else begin
      r.kind = KIND_NONE;
    end
    return r;
  endfunction

  assign pending = root_q.size();

  always @(posedge clk) begin
    roots_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      // predict on each accepted item
      if (start && !busy) root_q.push_back(solve_quadratic(in_coef_a, in_coef_b, in_coef_c));
      // compare each result with the oldest expectation
      if (out_valid) begin
        if (root_q.size() == 0) begin
          $error("unexpected result: kind %0d", out_root_kind);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = root_q.pop_front();
          if (out_root_kind !== exp_r.kind) begin
            $error("root_kind: expected %0d, actual %0d", exp_r.kind, out_root_kind);
            fail_count <= fail_count + 1;
          end else if (out_root_plus !== exp_r.rplus) begin
            $error("root_plus: expected %0d, actual %0d", exp_r.rplus, out_root_plus);
            fail_count <= fail_count + 1;
          end else if (out_root_minus !== exp_r.rminus) begin
            $error("root_minus: expected %0d, actual %0d", exp_r.rminus, out_root_minus);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/sv/tb.sv */
// Testbench top: stimulus and verdict for the quadratic real-root block.
`timescale 1ns / 100ps
module tb;
  import qrr_pkg::*;

  localparam int LATENCY = 55;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk, rst_n, start, busy, out_valid;
  logic signed [15:0] in_coef_a, in_coef_b, in_coef_c;
  logic [1:0] out_root_kind;
  logic signed [ROOT_WIDTH-1:0] out_root_plus, out_root_minus;
  int fail_count, pending, idle_cycles, sender_gap;

  quadratic_real_roots i_dut (.*);

  qrr_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog: cycles with nothing accepted and no result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // offer one item, holding it until accepted
  task automatic send_item(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    while ($urandom_range(99) < sender_gap) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // random coefficients: mostly small ranges so all root kinds show up
  task automatic send_random;
    logic [15:0] a, b, c;
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) begin
      a = $urandom;
      b = $urandom;
      c = $urandom;
    end else if (sel < 8) begin
      a = 16'($signed($urandom_range(40)) - 20);
      b = 16'($signed($urandom_range(200)) - 100);
      c = 16'($signed($urandom_range(200)) - 100);
    end else begin
      // perfect square: a(x-r)^2 gives a double root
      a = 16'($signed($urandom_range(20)) - 10);
      b = 16'($signed($urandom_range(40)) - 20);
      b = b * 2;
      c = (a != 0) ? 16'(($signed(b) * $signed(b)) / (4 * $signed(a))) : 16'(0);
      if (a != 0 && ($signed(b) * $signed(b)) % (4 * $signed(a)) != 0) a = 1;
      if (a == 1) c = 16'(($signed(b) * $signed(b)) / 4);
    end
    send_item(a, b, c);
  endtask

  initial begin
    int n;
    rst_n = 0;
    start = 0;
    in_coef_a = 0;
    in_coef_b = 0;
    in_coef_c = 0;
    sender_gap = 34;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes and each root kind
    send_item(16'h8000, 16'h8000, 16'h8000);
    send_item(16'h7fff, 16'h7fff, 16'h7fff);
    send_item(16'h7fff, 16'h8000, 16'h8000);
    send_item(16'h8000, 16'h7fff, 16'h7fff);
    send_item(16'h0001, 16'h8000, 16'h8000);
    send_item(16'h0000, 16'h1234, 16'hffff);
    send_item(16'h0000, 16'h0000, 16'h0000);
    send_item(16'h0001, 16'h0000, 16'h0000);
    send_item(16'h0001, 16'hfffe, 16'h0001);
    send_item(16'hffff, 16'h0002, 16'hffff);
    send_item(16'h0001, 16'h0000, 16'h0001);
    send_item(16'h0001, 16'hfffd, 16'h0002);
    send_item(16'hfffe, 16'h0003, 16'h0005);
    send_item(16'h0003, 16'h0001, 16'hffff);
    send_item(16'h0001, 16'h0001, 16'h0000);
    send_item(16'hffff, 16'hffff, 16'hffff);
    send_item(16'h5555, 16'haaaa, 16'h5555);

    // three idling phases
    for (n = 0; n < 1150; n++) begin
      if (n == 383) sender_gap = 45;
      if (n == 766) sender_gap = 0;
      send_random();
    end
    start <= 0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
